@@ hw/rtl/ts_pes_payload_assembler_macros.svh @@
// assertion helpers for the assembler rtl
`ifndef TS_PES_PAYLOAD_ASSEMBLER_MACROS_SVH
`define TS_PES_PAYLOAD_ASSEMBLER_MACROS_SVH

// same-cycle implication
`define TSPA_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// next-cycle implication
`define TSPA_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/tspa_pkg.sv @@
package tspa_pkg;

	localparam logic [7:0] PACKET_BYTES = 8'd188;
	localparam logic [7:0] SYNC_BYTE    = 8'h47;
	localparam logic [7:0] STUFF_BYTE   = 8'hFF;
	localparam logic [7:0] SID_PRIV2    = 8'hBF;
	localparam logic [7:0] SID_PRIV1    = 8'hBD;
	localparam logic [7:0] PREFIX_END   = 8'h01;

	// pes header progress
	localparam logic [3:0] STEP_SID    = 4'd3;
	localparam logic [3:0] STEP_LEN_HI = 4'd4;
	localparam logic [3:0] STEP_LEN_LO = 4'd5;
	localparam logic [3:0] STEP_HDRLEN = 4'd8;
	localparam logic [3:0] STEP_OPT    = 4'd9;
	localparam logic [3:0] STEP_DATA   = 4'd10;

	typedef enum logic [2:0] {
		ST_DATA     = 3'd0,
		ST_BAD_SYNC = 3'd1,
		ST_NO_START = 3'd2,
		ST_INVALID  = 3'd3,
		ST_CC_BREAK = 3'd4
	} status_t;

endpackage

@@ hw/rtl/ts_pes_payload_assembler.sv @@
// MPEG-2 transport stream to PES private data reassembler.
// Input channel: one transport byte per transfer (data_byte, packet_first),
// handshaken with in_valid / in_stall. packet_first marks byte 0 of a packet;
// without it bytes are counted against the 188-byte packet length.
// Output channel: at most one result per input byte (out_byte, unit_last,
// status), handshaken with out_valid / out_stall. status 0 carries a private
// data byte of a 0xBF or 0xBD PES unit, unit_last marks its final byte; any
// other status is an abort with out_byte zero and unit_last set.
// The byte is first held in the input register, then its result is loaded
// into the result register. Throughput: one byte per cycle while no held
// result is stalled by the receiver, limited by the single pass of header and
// payload logic between the two registers.
// Reset empties both registers and clears all parsing state; no unit is open after it.
// When the receiver stalls with a result held, a byte in the input register
// waits there and in_stall stays high until the held result is taken.
module ts_pes_payload_assembler
	import tspa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       packet_first,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       unit_last,
	output logic [2:0] status
);

`include "ts_pes_payload_assembler_macros.svh"

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        unit_last_q;
	status_t     status_q;

	logic [7:0]  byte_pos_q,   n_pos;
	logic [3:0]  last_cc_q,    n_last_cc;
	logic        cc_known_q,   n_cc_known;
	logic        collect_q,    n_collect;
	logic        unit_done_q,  n_unit_done;
	logic [2:0]  flags_q,      n_flags;
	logic [7:0]  skip_q,       n_skip;
	logic [3:0]  step_q,       n_step;
	logic [7:0]  sid_q,        n_sid;
	logic [15:0] pes_len_q,    n_pes_len;
	logic [16:0] remain_q,     n_remain;

	logic        adv;
	logic [7:0]  pos;
	logic [8:0]  start;
	logic        take, proceed, abort;
	status_t     abort_st;
	logic        res_v, res_last;
	logic [7:0]  res_byte;
	status_t     res_st;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1  <= data_byte;
			first_s1 <= packet_first;
		end
	end

	always_comb begin
		n_pos       = byte_pos_q;
		n_last_cc   = last_cc_q;
		n_cc_known  = cc_known_q;
		n_collect   = collect_q;
		n_unit_done = unit_done_q;
		n_flags     = flags_q;
		n_skip      = skip_q;
		n_step      = step_q;
		n_sid       = sid_q;
		n_pes_len   = pes_len_q;
		n_remain    = remain_q;
		take        = 1'b0;
		proceed     = 1'b0;
		abort       = 1'b0;
		abort_st    = ST_INVALID;
		res_v       = 1'b0;
		res_last    = 1'b0;
		res_byte    = 8'd0;
		res_st      = ST_DATA;
		pos         = first_s1 ? 8'd0 : byte_pos_q;
		start       = flags_q[1] ? (9'd5 + {1'b0, byte_s1}) : 9'd4;

		if (pos < PACKET_BYTES) begin
			n_pos = pos + 8'd1;
			if (pos == 8'd0) begin
				n_flags   = 3'd0;
				n_collect = 1'b0;
				n_skip    = 8'd0;
				if (byte_s1 != SYNC_BYTE) begin
					abort    = 1'b1;
					abort_st = ST_BAD_SYNC;
				end
			end else if (pos == 8'd1) begin
				n_flags = {2'b00, byte_s1[6]};
			end else if (pos == 8'd2) begin
				n_flags = flags_q;
			end else if (pos == 8'd3) begin
				n_flags = {byte_s1[4], byte_s1[5], flags_q[0]};
				if (!cc_known_q) begin
					n_cc_known = 1'b1;
					n_last_cc  = byte_s1[3:0];
				end else begin
					n_last_cc = last_cc_q + 4'd1;
					if (n_last_cc != byte_s1[3:0]) begin
						// break: drop the unit but keep parsing this packet
						n_unit_done = 1'b1;
						n_step      = 4'd0;
						n_cc_known  = 1'b0;
						n_remain    = 17'd0;
						n_skip      = 8'd0;
						n_collect   = 1'b0;
						res_v       = 1'b1;
						res_last    = 1'b1;
						res_st      = ST_CC_BREAK;
					end
				end
			end else if (pos == 8'd4) begin
				if (!flags_q[2]) begin
					n_collect = 1'b0;
					n_pos     = PACKET_BYTES;
				end else if (!flags_q[0] && unit_done_q) begin
					abort    = 1'b1;
					abort_st = ST_NO_START;
				end else if (flags_q[0] && (!unit_done_q || start > {1'b0, PACKET_BYTES})) begin
					abort    = 1'b1;
					abort_st = ST_INVALID;
				end else if (start >= {1'b0, PACKET_BYTES}) begin
					// no room for payload
					n_unit_done = 1'b1;
					n_step      = 4'd0;
					n_cc_known  = 1'b0;
					n_remain    = 17'd0;
					n_skip      = 8'd0;
					n_collect   = 1'b0;
					n_pos       = PACKET_BYTES;
					if (!unit_done_q) begin
						res_v    = 1'b1;
						res_last = 1'b1;
						res_st   = ST_INVALID;
					end
				end else begin
					n_collect = 1'b1;
					if (flags_q[0]) begin
						n_unit_done = 1'b0;
						n_step      = 4'd0;
					end
					if (flags_q[1]) begin
						n_skip = byte_s1;
					end else begin
						take = 1'b1;
					end
				end
			end else if (collect_q) begin
				if (skip_q != 8'd0) begin
					n_skip = skip_q - 8'd1;
				end else begin
					take = 1'b1;
				end
			end
		end

		if (take) begin
			if (n_unit_done) begin
				if (byte_s1 == STUFF_BYTE) begin
					n_collect = 1'b0;
					n_pos     = PACKET_BYTES;
				end else begin
					n_unit_done = 1'b0;
					n_step      = 4'd0;
					proceed     = 1'b1;
				end
			end else begin
				proceed = 1'b1;
			end
		end

		if (proceed) begin
			if (n_step < STEP_SID) begin
				// start code prefix 00 00 01
				if (byte_s1 != ((n_step == 4'd2) ? PREFIX_END : 8'd0)) begin
					abort = 1'b1;
				end else begin
					n_step = n_step + 4'd1;
				end
			end else if (n_step == STEP_SID) begin
				if (byte_s1 != SID_PRIV2 && byte_s1 != SID_PRIV1) begin
					abort = 1'b1;
				end else begin
					n_sid  = byte_s1;
					n_step = STEP_LEN_HI;
				end
			end else if (n_step == STEP_LEN_HI) begin
				n_pes_len = {byte_s1, 8'd0};
				n_step    = STEP_LEN_LO;
			end else if (n_step == STEP_LEN_LO) begin
				n_pes_len = {pes_len_q[15:8], byte_s1};
				if (sid_q == SID_PRIV2) begin
					if (n_pes_len == 16'd0) begin
						abort = 1'b1;
					end else begin
						n_remain = {1'b0, n_pes_len};
						n_step   = STEP_DATA;
					end
				end else begin
					n_step = n_step + 4'd1;
				end
			end else if (n_step < STEP_HDRLEN) begin
				n_step = n_step + 4'd1;
			end else if (n_step == STEP_HDRLEN) begin
				if ({1'b0, pes_len_q} <= (17'd3 + {9'd0, byte_s1})) begin
					abort = 1'b1;
				end else begin
					n_remain = {1'b0, pes_len_q} - 17'd3 - {9'd0, byte_s1};
					if (byte_s1 == 8'd0) begin
						n_step = STEP_DATA;
					end else begin
						n_pes_len = {8'd0, byte_s1};
						n_step    = STEP_OPT;
					end
				end
			end else if (n_step == STEP_OPT) begin
				n_pes_len = pes_len_q - 16'd1;
				if (n_pes_len == 16'd0) begin
					n_step = STEP_DATA;
				end
			end else begin
				if (remain_q != 17'd0) begin
					n_remain = remain_q - 17'd1;
				end
				res_v    = 1'b1;
				res_byte = byte_s1;
				res_st   = ST_DATA;
				if (n_remain == 17'd0) begin
					n_unit_done = 1'b1;
					n_step      = 4'd0;
					res_last    = 1'b1;
				end
			end
		end

		if (abort) begin
			n_unit_done = 1'b1;
			n_step      = 4'd0;
			n_cc_known  = 1'b0;
			n_remain    = 17'd0;
			n_skip      = 8'd0;
			n_collect   = 1'b0;
			n_pos       = PACKET_BYTES;
			res_v       = 1'b1;
			res_last    = 1'b1;
			res_byte    = 8'd0;
			res_st      = abort_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q  <= 8'd0;
			last_cc_q   <= 4'd0;
			cc_known_q  <= 1'b0;
			collect_q   <= 1'b0;
			unit_done_q <= 1'b1;
			flags_q     <= 3'd0;
			skip_q      <= 8'd0;
			step_q      <= 4'd0;
			sid_q       <= 8'd0;
			pes_len_q   <= 16'd0;
			remain_q    <= 17'd0;
		end else if (adv) begin
			byte_pos_q  <= n_pos;
			last_cc_q   <= n_last_cc;
			cc_known_q  <= n_cc_known;
			collect_q   <= n_collect;
			unit_done_q <= n_unit_done;
			flags_q     <= n_flags;
			skip_q      <= n_skip;
			step_q      <= n_step;
			sid_q       <= n_sid;
			pes_len_q   <= n_pes_len;
			remain_q    <= n_remain;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_v;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (adv && res_v) begin
			out_byte_q  <= res_byte;
			unit_last_q <= res_last;
			status_q    <= res_st;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign unit_last = unit_last_q;
	assign status    = status_q;

	`TSPA_ASSERT_NOW(a_abort_is_last, out_valid && status != ST_DATA, unit_last && out_byte == 8'd0)
	`TSPA_ASSERT_NOW(a_stall_cause, in_stall, valid_s1 && out_valid_q && out_stall)
	`TSPA_ASSERT_NEXT(a_last_closes, adv && res_v && res_last, unit_done_q && step_q == 4'd0)
	`TSPA_ASSERT_NOW(a_pos_range, valid_s1, byte_pos_q <= PACKET_BYTES)
	`TSPA_ASSERT_NEXT(a_cc_drop, adv && res_v && res_st != ST_DATA, !cc_known_q && !collect_q)

endmodule
